// ----- rtl/dedc_pkg.sv -----
package dedc_pkg;

    // config port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_INPUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 2'd2;

    localparam logic [1:0] EDGE_RISING  = 2'd0;
    localparam logic [1:0] EDGE_FALLING = 2'd1;
    localparam logic [1:0] EDGE_ANY     = 2'd2;
    localparam logic [1:0] EDGE_NONE    = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_FILTERING = 2'd1,
        PH_QUALIFIED = 2'd2,
        PH_INHIBITED = 2'd3
    } t_phase;

    typedef struct packed {
        logic        sample;
        logic        force_active;
        logic        forced_level;
        logic        set_enable;
        logic        reset_request;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        edge_pulse;
        logic [31:0] event_count;
        logic        command_level;
        logic        actual_level;
        logic        set_met;
        logic        reset_met;
        logic        reset_override;
    } t_out_word;

    // handshake between input register and core
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_in_slot;

endpackage

// ----- rtl/dedc_in_stage.sv -----
module dedc_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dedc_pkg::t_in_word i_in_word,
    output logic              o_in_stall,
    input  logic              i_advance,
    output dedc_pkg::t_in_slot o_slot
);

    logic              r_valid;
    logic              n_valid;
    dedc_pkg::t_in_word r_word;
    logic              accept;

    // register may refill in the same cycle it hands its word on
    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_in_word;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.word  = r_word;

endmodule

// ----- rtl/dedc_core.sv -----
module dedc_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dedc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dedc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  dedc_pkg::t_in_slot                  i_slot,
    input  logic                                i_fire,
    output dedc_pkg::t_out_word                 o_result
);

    // config
    logic        r_invert;
    logic [1:0]  r_edge_mode;
    logic [15:0] r_debounce;

    // filter state
    dedc_pkg::t_phase r_phase;
    dedc_pkg::t_phase n_phase;
    logic [31:0] r_window_start;
    logic [31:0] n_window_start;
    logic        r_pending;
    logic        n_pending;
    logic [31:0] r_count;
    logic [31:0] n_count;
    logic        r_command;
    logic        n_command;
    logic        r_edge;
    logic        n_edge;
    logic        r_prev;
    logic        r_prev_valid;

    dedc_pkg::t_in_word w;
    logic        raw;
    logic        lvl;
    logic        prev;
    logic        rising;
    logic        falling;
    logic        match;
    logic [31:0] elapsed;
    logic        held;
    logic        deb_zero;

    assign w        = i_slot.word;
    assign raw      = w.force_active ? w.forced_level : w.sample;
    assign lvl      = raw ^ r_invert;
    assign prev     = r_prev_valid ? r_prev : lvl;
    assign rising   = !prev && lvl;
    assign falling  = prev && !lvl;
    assign elapsed  = w.now_ms - r_window_start;
    assign deb_zero = (r_debounce == 16'd0);
    assign held     = deb_zero || (elapsed >= {16'd0, r_debounce});

    always_comb begin
        case (r_edge_mode)
            dedc_pkg::EDGE_RISING:  match = rising;
            dedc_pkg::EDGE_FALLING: match = falling;
            dedc_pkg::EDGE_ANY:     match = rising || falling;
            default:                match = 1'b0;
        endcase
    end

    // next phase
    always_comb begin
        if (w.reset_request) begin
            n_phase = dedc_pkg::PH_INHIBITED;
        end else if (!w.set_enable) begin
            n_phase = dedc_pkg::PH_IDLE;
        end else if (r_phase == dedc_pkg::PH_FILTERING) begin
            if (lvl != r_pending) begin
                n_phase = dedc_pkg::PH_IDLE;
            end else if (!held) begin
                n_phase = dedc_pkg::PH_FILTERING;
            end else begin
                n_phase = dedc_pkg::PH_QUALIFIED;
            end
        end else if (!match) begin
            n_phase = dedc_pkg::PH_IDLE;
        end else if (deb_zero) begin
            n_phase = dedc_pkg::PH_QUALIFIED;
        end else begin
            n_phase = dedc_pkg::PH_FILTERING;
        end
    end

    // datapath: a qualification is every step whose next phase is qualified
    always_comb begin
        n_window_start = r_window_start;
        n_pending      = r_pending;
        n_count        = r_count;
        n_command      = r_command;
        n_edge         = 1'b0;
        if (w.reset_request) begin
            n_window_start = 32'd0;
            n_pending      = 1'b0;
            n_count        = 32'd0;
        end else if (w.set_enable && r_phase != dedc_pkg::PH_FILTERING && match) begin
            n_window_start = w.now_ms;
            n_pending      = lvl;
        end
        if (!w.reset_request && n_phase == dedc_pkg::PH_QUALIFIED) begin
            n_edge         = 1'b1;
            n_count        = r_count + 32'd1;
            n_command      = lvl;
            n_window_start = w.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert    <= 1'b0;
            r_edge_mode <= dedc_pkg::EDGE_RISING;
            r_debounce  <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dedc_pkg::CFG_INVERT_INPUT: r_invert    <= i_cfg_data[0];
                dedc_pkg::CFG_EDGE_MODE:    r_edge_mode <= i_cfg_data[1:0];
                dedc_pkg::CFG_DEBOUNCE_MS:  r_debounce  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= dedc_pkg::PH_IDLE;
            r_window_start <= 32'd0;
            r_pending      <= 1'b0;
            r_count        <= 32'd0;
            r_command      <= 1'b0;
            r_edge         <= 1'b0;
            r_prev         <= 1'b0;
            r_prev_valid   <= 1'b0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_window_start <= n_window_start;
            r_pending      <= n_pending;
            r_count        <= n_count;
            r_command      <= n_command;
            r_edge         <= n_edge;
            r_prev         <= lvl;
            r_prev_valid   <= 1'b1;
        end
    end

    assign o_result.status         = n_phase;
    assign o_result.edge_pulse     = n_edge;
    assign o_result.event_count    = n_count;
    assign o_result.command_level  = n_command;
    assign o_result.actual_level   = lvl;
    assign o_result.set_met        = w.set_enable;
    assign o_result.reset_met      = w.reset_request;
    assign o_result.reset_override = w.set_enable && w.reset_request;

    // pulse only with the qualified phase
    a_edge_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge |-> (r_phase == dedc_pkg::PH_QUALIFIED))
        else $error("edge flag outside qualified phase");

    // reset request wipes the counter and inhibits
    a_rst_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w.reset_request) |=>
            (r_count == 32'd0 && r_phase == dedc_pkg::PH_INHIBITED && !r_edge))
        else $error("reset request did not clear the filter");

    // counter only steps by one, and only with a pulse
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !w.reset_request) |=>
            ((r_count == $past(r_count) + 32'd1) == r_edge))
        else $error("counter step does not match edge pulse");

    // state frozen without an item
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_count) && $stable(r_phase) && $stable(r_prev)))
        else $error("state changed without an item");

    // only a held word is processed
    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> i_slot.valid)
        else $error("processed an empty input register");

endmodule

// ----- rtl/dedc_out_stage.sv -----
module dedc_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dedc_pkg::t_out_word i_result,
    output logic                o_out_valid,
    output dedc_pkg::t_out_word o_out_word,
    input  logic                i_out_stall,
    output logic                o_advance
);

    logic                r_valid;
    logic                n_valid;
    dedc_pkg::t_out_word r_word;

    // free, or being taken this cycle
    assign o_advance = !r_valid || !i_out_stall;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

// ----- rtl/debounced_edge_event_counter.sv -----
// Debounced edge counter for one digital input.
//
// Input channel (i_in_valid / o_in_stall / i_in_word): one word per sample,
// carrying the raw level, force controls, set/reset requests and a ms
// timestamp. A word is taken on a clock edge with valid high and stall low.
// Output channel (o_out_valid / i_out_stall / o_out_word): one result word per
// input word, in order: phase, edge pulse, event count, latched command level,
// effective level and the set/reset echoes.
// Config port (i_cfg_we / i_cfg_idx / i_cfg_data): 0 invert_input,
// 1 edge_mode, 2 debounce_ms. Write only while no word is in flight.
//
// Timing: a word is held in the input register, then makes one combinational
// pass into the result register once that register is free or being taken.
// Throughput: 1 word per cycle while the output side does not stall; the state
// update is a single compare/subtract/increment pass.
// Stall: while the result register is held, one more word still enters the
// input register; the input side stalls only when both are full.
// Reset (synchronous, i_rst_n low): pipeline empties, config clears to zero,
// phase idle, counter and previous sample cleared.
module debounced_edge_event_counter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dedc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dedc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  dedc_pkg::t_in_word               i_in_word,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output dedc_pkg::t_out_word              o_out_word,
    input  logic                             i_out_stall
);

    dedc_pkg::t_in_slot  slot;
    dedc_pkg::t_out_word result;
    logic                advance;
    logic                fire;

    // a word is processed when it sits in the input register and the
    // result register can take its answer
    assign fire = slot.valid && advance;

    dedc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_advance  (advance),
        .o_slot     (slot)
    );

    dedc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_slot     (slot),
        .i_fire     (fire),
        .o_result   (result)
    );

    dedc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_result    (result),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .o_advance   (advance)
    );

endmodule
